// ----- src/i2cms_pkg.sv -----
// ----------------------------------------------------------------------------
// I2C master transfer sequencer package
// Shared types, codes and status constants for the transfer sequencer.
// ----------------------------------------------------------------------------
package i2cms_pkg;

  // Transfer phase
  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_WR     = 3'd1,
    PH_RD     = 3'd2,
    PH_WR16   = 3'd3,
    PH_RD16   = 3'd4,
    PH_RDADDR = 3'd5
  } phase_e;

  // Error kept during a transfer
  localparam logic [1:0] ERR_OK   = 2'd0;
  localparam logic [1:0] ERR_NACK = 2'd1;
  localparam logic [1:0] ERR_ARB  = 2'd2;
  localparam logic [1:0] ERR_BUS  = 2'd3;

  // Reported status
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_BUSY    = 3'd4;
  localparam logic [2:0] ST_INVALID = 3'd5;

  // Start and acknowledge control
  localparam logic [1:0] START_LEAVE = 2'd0;
  localparam logic [1:0] START_SET   = 2'd1;
  localparam logic [1:0] START_CLR   = 2'd2;
  localparam logic [1:0] ACK_LEAVE   = 2'd0;
  localparam logic [1:0] ACK_EN      = 2'd1;
  localparam logic [1:0] ACK_DIS     = 2'd2;

  // Transfer modes
  localparam logic [1:0] MODE_PTR8   = 2'd0;
  localparam logic [1:0] MODE_PTR16  = 2'd1;
  localparam logic [1:0] MODE_RDONLY = 2'd2;

  // Configuration register indexes
  localparam logic CFG_SLAVE_ADDR = 1'b0;
  localparam logic CFG_MODE       = 1'b1;

  // Request kinds
  localparam logic REQ_TRANSFER = 1'b0;

  // Bus engine status codes
  localparam logic [7:0] SC_BUS_ERR    = 8'h00;
  localparam logic [7:0] SC_START      = 8'h08;
  localparam logic [7:0] SC_RSTART     = 8'h10;
  localparam logic [7:0] SC_SLAW_ACK   = 8'h18;
  localparam logic [7:0] SC_SLAW_NACK  = 8'h20;
  localparam logic [7:0] SC_DATA_ACK   = 8'h28;
  localparam logic [7:0] SC_DATA_NACK  = 8'h30;
  localparam logic [7:0] SC_ARB_LOST   = 8'h38;
  localparam logic [7:0] SC_SLAR_ACK   = 8'h40;
  localparam logic [7:0] SC_SLAR_NACK  = 8'h48;
  localparam logic [7:0] SC_RX_ACK     = 8'h50;
  localparam logic [7:0] SC_RX_NACK    = 8'h58;

  typedef struct packed {
    logic        req_type;
    logic        op_read;
    logic [15:0] location;
    logic [15:0] byte_count;
    logic [7:0]  status_code;
    logic [7:0]  rx_byte;
    logic [7:0]  tx_byte;
  } item_t;

  typedef struct packed {
    logic       tx_load;
    logic [7:0] tx_value;
    logic [1:0] start_action;
    logic [1:0] ack_action;
    logic       stop_request;
    logic       rx_valid;
    logic       done_res;
    logic [2:0] status;
  } result_t;

  typedef struct packed {
    phase_e      phase;
    logic [15:0] remaining;
    logic [15:0] pointer_value;
    logic [1:0]  error_code;
    logic [6:0]  addr;
  } state_t;

endpackage

// ----- src/i2cms_step.sv -----
// ----------------------------------------------------------------------------
// I2C master sequencer step logic
// Decides the next bus action and the next state for one request or event.
// ----------------------------------------------------------------------------
module i2cms_step (
  input  i2cms_pkg::item_t   item_i,
  input  i2cms_pkg::state_t  state_i,
  input  logic [6:0]         slave_address_i,
  input  logic [1:0]         transfer_mode_i,
  output i2cms_pkg::result_t res_o,
  output i2cms_pkg::state_t  state_o
);

  logic        mode_ok;
  logic [15:0] rem_dec;
  logic        busy;

  assign busy    = (state_i.phase != i2cms_pkg::PH_IDLE);
  // receive never wraps below zero
  assign rem_dec = (state_i.remaining != 16'd0) ? state_i.remaining - 16'd1 : 16'd0;

  always_comb begin
    res_o   = '0;
    state_o = state_i;
    mode_ok = 1'b1;
    if (item_i.req_type == i2cms_pkg::REQ_TRANSFER) begin
      if (busy) begin
        res_o.done_res = 1'b1;
        res_o.status   = i2cms_pkg::ST_BUSY;
      end else if (item_i.byte_count == 16'd0) begin
        res_o.done_res = 1'b1;
        res_o.status   = i2cms_pkg::ST_OK;
      end else begin
        case (transfer_mode_i)
          i2cms_pkg::MODE_PTR8: begin
            state_o.pointer_value = {item_i.location[7:0], 8'h00};
            state_o.phase = item_i.op_read ? i2cms_pkg::PH_RD : i2cms_pkg::PH_WR;
          end
          i2cms_pkg::MODE_PTR16: begin
            state_o.pointer_value = item_i.location;
            state_o.phase = item_i.op_read ? i2cms_pkg::PH_RD16 : i2cms_pkg::PH_WR16;
          end
          i2cms_pkg::MODE_RDONLY: begin
            if (item_i.op_read) begin
              state_o.phase = i2cms_pkg::PH_RDADDR;
            end else begin
              mode_ok = 1'b0;
            end
          end
          default: mode_ok = 1'b0;
        endcase
        if (mode_ok) begin
          state_o.remaining    = item_i.byte_count;
          state_o.addr         = slave_address_i;
          state_o.error_code   = i2cms_pkg::ERR_OK;
          res_o.start_action   = i2cms_pkg::START_SET;
        end else begin
          state_o              = state_i;
          res_o.done_res       = 1'b1;
          res_o.status         = i2cms_pkg::ST_INVALID;
        end
      end
    end else if (busy) begin
      case (item_i.status_code)
        i2cms_pkg::SC_START, i2cms_pkg::SC_RSTART: begin
          state_o.error_code = i2cms_pkg::ERR_OK;
          res_o.tx_load      = 1'b1;
          res_o.tx_value     = {state_i.addr, state_i.phase == i2cms_pkg::PH_RDADDR};
          res_o.ack_action   = i2cms_pkg::ACK_EN;
          res_o.start_action = i2cms_pkg::START_CLR;
        end
        i2cms_pkg::SC_SLAW_ACK: begin
          res_o.tx_load    = 1'b1;
          res_o.tx_value   = state_i.pointer_value[15:8];
          res_o.ack_action = i2cms_pkg::ACK_EN;
        end
        i2cms_pkg::SC_DATA_ACK: begin
          if (state_i.phase == i2cms_pkg::PH_WR16 || state_i.phase == i2cms_pkg::PH_RD16) begin
            res_o.tx_load    = 1'b1;
            res_o.tx_value   = state_i.pointer_value[7:0];
            res_o.ack_action = i2cms_pkg::ACK_EN;
            state_o.phase = (state_i.phase == i2cms_pkg::PH_WR16) ? i2cms_pkg::PH_WR
                                                                   : i2cms_pkg::PH_RD;
          end else if (state_i.phase == i2cms_pkg::PH_RD) begin
            // pointer sent, turn round with a repeated start
            res_o.start_action = i2cms_pkg::START_SET;
            res_o.ack_action   = i2cms_pkg::ACK_EN;
            state_o.phase      = i2cms_pkg::PH_RDADDR;
          end else if (state_i.remaining != 16'd0) begin
            res_o.tx_load     = 1'b1;
            res_o.tx_value    = item_i.tx_byte;
            res_o.ack_action  = i2cms_pkg::ACK_EN;
            state_o.remaining = state_i.remaining - 16'd1;
          end else begin
            res_o.stop_request = 1'b1;
            res_o.ack_action   = i2cms_pkg::ACK_EN;
            res_o.done_res     = 1'b1;
            res_o.status       = {1'b0, state_i.error_code};
            state_o.phase      = i2cms_pkg::PH_IDLE;
          end
        end
        i2cms_pkg::SC_SLAW_NACK, i2cms_pkg::SC_DATA_NACK, i2cms_pkg::SC_SLAR_NACK: begin
          res_o.stop_request = 1'b1;
          res_o.done_res     = 1'b1;
          res_o.status       = {1'b0, i2cms_pkg::ERR_NACK};
          state_o.remaining  = 16'd0;
          state_o.error_code = i2cms_pkg::ERR_NACK;
          state_o.phase      = i2cms_pkg::PH_IDLE;
        end
        i2cms_pkg::SC_ARB_LOST: begin
          res_o.stop_request = 1'b1;
          res_o.done_res     = 1'b1;
          res_o.status       = {1'b0, i2cms_pkg::ERR_ARB};
          state_o.remaining  = 16'd0;
          state_o.error_code = i2cms_pkg::ERR_ARB;
          state_o.phase      = i2cms_pkg::PH_IDLE;
        end
        i2cms_pkg::SC_SLAR_ACK: begin
          res_o.ack_action = (state_i.remaining > 16'd1) ? i2cms_pkg::ACK_EN
                                                         : i2cms_pkg::ACK_DIS;
        end
        i2cms_pkg::SC_RX_ACK: begin
          state_o.remaining = rem_dec;
          res_o.rx_valid    = 1'b1;
          res_o.ack_action  = (rem_dec > 16'd1) ? i2cms_pkg::ACK_EN : i2cms_pkg::ACK_DIS;
        end
        i2cms_pkg::SC_RX_NACK: begin
          state_o.remaining  = rem_dec;
          res_o.rx_valid     = 1'b1;
          res_o.stop_request = 1'b1;
          res_o.done_res     = 1'b1;
          res_o.status       = {1'b0, state_i.error_code};
          state_o.phase      = i2cms_pkg::PH_IDLE;
        end
        i2cms_pkg::SC_BUS_ERR: begin
          res_o.stop_request = 1'b1;
          res_o.done_res     = 1'b1;
          res_o.status       = {1'b0, i2cms_pkg::ERR_BUS};
          state_o.error_code = i2cms_pkg::ERR_BUS;
          state_o.phase      = i2cms_pkg::PH_IDLE;
        end
        default: ;
      endcase
    end
  end

endmodule

// ----- src/i2c_master_transfer_sequencer.sv -----
// ----------------------------------------------------------------------------
// I2C master transfer sequencer
// Turns transfer requests and byte engine status events into bus actions.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries either a transfer request
//   (req_type 0) or a bus status event (req_type 1). Every accepted item gives
//   exactly one result on the output channel (out_valid_o/out_ready_i).
//   Configuration registers (0 slave address, 1 transfer mode) are written
//   through cfg_valid_i/cfg_index_i/cfg_data_i; cfg_ready_o is always high.
//   Write them only while no transfer is pending.
//   An item is captured in the input register and decided from there into
//   the result register once that register is free or being read.
//   Throughput is one item per cycle while the receiver does not stall; the
//   single decision stage between the two registers sets that.
//   When the receiver stalls, the result register holds and the input
//   register fills; in_ready_o drops only once both are occupied.
//   Reset clears the channels, the configuration and the transfer state to
//   idle.
// ----------------------------------------------------------------------------
module i2c_master_transfer_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [6:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        req_type_i,
  input  logic        op_read_i,
  input  logic [15:0] location_i,
  input  logic [15:0] byte_count_i,
  input  logic [7:0]  status_code_i,
  input  logic [7:0]  rx_byte_i,
  input  logic [7:0]  tx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        tx_load_o,
  output logic [7:0]  tx_value_o,
  output logic [1:0]  start_action_o,
  output logic [1:0]  ack_action_o,
  output logic        stop_request_o,
  output logic        rx_valid_o,
  output logic        done_res_o,
  output logic [2:0]  status_o
);

  logic [6:0]         slave_address_q;
  logic [1:0]         transfer_mode_q;
  logic               s1_valid_q;
  i2cms_pkg::item_t   s1_item_q;
  logic               out_valid_q;
  i2cms_pkg::result_t out_res_q;
  i2cms_pkg::state_t  state_q;
  i2cms_pkg::state_t  state_d;
  i2cms_pkg::result_t res_d;
  logic               adv;
  logic               fire;

  assign cfg_ready_o = 1'b1;
  assign adv         = !out_valid_q || out_ready_i;
  assign fire        = s1_valid_q && adv;
  assign in_ready_o  = !s1_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_address_q <= '0;
      transfer_mode_q <= '0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == i2cms_pkg::CFG_SLAVE_ADDR) begin
        slave_address_q <= cfg_data_i;
      end else begin
        transfer_mode_q <= cfg_data_i[1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_item_q <= '{req_type: req_type_i, op_read: op_read_i, location: location_i,
                     byte_count: byte_count_i, status_code: status_code_i,
                     rx_byte: rx_byte_i, tx_byte: tx_byte_i};
    end
  end

  i2cms_step u_step (
    .item_i          (s1_item_q),
    .state_i         (state_q),
    .slave_address_i (slave_address_q),
    .transfer_mode_i (transfer_mode_q),
    .res_o           (res_d),
    .state_o         (state_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '{phase: i2cms_pkg::PH_IDLE, remaining: '0, pointer_value: '0,
                       error_code: i2cms_pkg::ERR_OK, addr: '0};
      out_valid_q <= 1'b0;
    end else if (fire) begin
      state_q     <= state_d;
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_res_q <= res_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign tx_load_o      = out_res_q.tx_load;
  assign tx_value_o     = out_res_q.tx_value;
  assign start_action_o = out_res_q.start_action;
  assign ack_action_o   = out_res_q.ack_action;
  assign stop_request_o = out_res_q.stop_request;
  assign rx_valid_o     = out_res_q.rx_valid;
  assign done_res_o     = out_res_q.done_res;
  assign status_o       = out_res_q.status;

endmodule

// ----- src/i2cms_checker.sv -----
// ----------------------------------------------------------------------------
// I2C master sequencer port checker
// Watches the top-level ports for result consistency and output holding.
// ----------------------------------------------------------------------------
module i2cms_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       tx_load_o,
  input logic [7:0] tx_value_o,
  input logic [1:0] start_action_o,
  input logic       done_res_o,
  input logic [2:0] status_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(tx_value_o) && $stable(status_o))
    else $error("stalled result changed");

  // a status is only reported on completion
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !done_res_o |-> status_o == i2cms_pkg::ST_OK)
    else $error("status without completion");

  // nothing to send means a zero byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !tx_load_o |-> tx_value_o == 8'h00)
    else $error("tx value without load");

  // a refused request leaves the bus alone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == i2cms_pkg::ST_BUSY || status_o == i2cms_pkg::ST_INVALID)
    |-> start_action_o == i2cms_pkg::START_LEAVE && !tx_load_o)
    else $error("refused request drove the bus");

endmodule

bind i2c_master_transfer_sequencer i2cms_checker u_checker (.*);
